/* rtl/ffba_pkg.sv */
// Shared types and codes for the first-fit block allocator.
// Depends on nothing; used by the controller, the datapath and the top level.
package ffba_pkg;

  // Action codes
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HEAP  = 2'd1;
  localparam logic [1:0] ST_TABLE = 2'd2;
  localparam logic [1:0] ST_ADDR  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [16:0] request_bytes;
    logic [15:0] data_address;
  } item_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } result_t;

  // Table write operations
  typedef enum logic [2:0] {
    WR_NONE, WR_SHIFT, WR_REST, WR_SHRINK, WR_APPEND, WR_FREE
  } wr_op_t;

  // Result address source
  typedef enum logic [1:0] {
    ASEL_NONE, ASEL_START, ASEL_TOP
  } asel_t;

  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       rd_en;
    logic       rd_k;
    logic       adv;
    logic       fit;
    logic       found_latch;
    logic       k_init;
    logic       k_dec;
    logic       cnt_inc;
    wr_op_t     wr;
    logic       res_set;
    logic [1:0] res_st;
    asel_t      res_sel;
  } ctl_t;

  typedef struct packed {
    logic [1:0] action;
    logic       daddr_zero;
    logic       scan_end;
    logic       hit;
    logic       k_done;
    logic       full;
    logic       heap_ok;
    logic       splittable;
  } sts_t;

endpackage

/* rtl/first_fit_block_allocator_core.sv */
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
// Usage: drive item (action, request_bytes, data_address) and raise start
// while busy is low; that edge accepts the beat. busy stays high until the
// result beat has been shown. Each item gives exactly one result beat on
// result (result_address, status), marked by done for one cycle; the
// receiver takes it at that edge and cannot stall it.
// Sequencing: a table scan visits each entry in two states (S_SCAN_RD reads
// the memory, S_SCAN_EV compares), and a split shifts the entries above the
// split point one at a time (S_SHIFT_RD, S_SHIFT_WR) before it writes the
// remainder and the shrunk entry. After the done cycle the controller returns
// to idle before the next beat is accepted. One item is in flight at a time.
// Reset: rst (synchronous) empties the table and sets the heap top to zero;
// no clearing pass is needed, entries beyond the block count are unused.
module first_fit_block_allocator_core #(
  parameter int HEAP_BYTES   = 65536,
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ffba_pkg::item_t   item,
  output logic              done,
  output ffba_pkg::result_t result
);

  ffba_pkg::ctl_t ctl;
  ffba_pkg::sts_t sts;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  ffba_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

endmodule

/* rtl/ffba_datapath.sv */
// Datapath of the first-fit block allocator: block table memory, scan
// position, heap top, split shifter index and result registers. Uses ffba_pkg.
module ffba_datapath #(
  parameter int HEAP_BYTES   = 65536,
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  ffba_pkg::item_t item,
  input  ffba_pkg::ctl_t  ctl,
  output ffba_pkg::sts_t  sts,
  output ffba_pkg::result_t result
);

  localparam int HW = $clog2(HEAP_BYTES + 1);
  localparam int SW = (HW > 17) ? HW : 17;
  localparam int XW = SW + 2;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);

  // Table entry: {free, size}
  logic [SW:0] mem [MAX_BLOCKS];
  logic [SW:0] rdata;

  logic [1:0]    act;
  logic [16:0]   req;
  logic [15:0]   daddr;
  logic [CW-1:0] idx;
  logic [XW-1:0] pos;
  logic [CW-1:0] k;
  logic [IW-1:0] fidx;
  logic [XW-1:0] fstart;
  logic [SW-1:0] fsize;
  logic [CW-1:0] count;
  logic [XW-1:0] top;
  logic [15:0]   res_addr;
  logic [1:0]    res_st;

  logic [XW-1:0] req_x, size_x, fsize_x, need_x, start_addr, top_addr;
  logic [CW-1:0] km1;
  logic [IW-1:0] raddr, waddr;
  logic [SW:0]   wdata;
  logic          we;

  assign req_x      = XW'(req);
  assign size_x     = XW'(rdata[SW-1:0]);
  assign fsize_x    = XW'(fsize);
  assign need_x     = req_x + HDR_X;
  assign start_addr = fstart + HDR_X;
  assign top_addr   = top + HDR_X;
  assign km1        = k - CW'(1);
  assign raddr      = ctl.rd_k ? km1[IW-1:0] : idx[IW-1:0];

  // Status toward the controller
  always_comb begin
    sts.action     = act;
    sts.daddr_zero = (daddr == '0);
    sts.scan_end   = (idx == count);
    sts.hit        = ctl.fit ? (rdata[SW] && (size_x > need_x))
                             : ((pos + HDR_X) == XW'(daddr));
    sts.k_done     = (k == (CW'(fidx) + CW'(1)));
    sts.full       = (count == CW'(MAX_BLOCKS));
    sts.heap_ok    = ((top + need_x) <= HEAP_X);
    sts.splittable = (fsize_x > need_x);
  end

  // Table write port select
  always_comb begin
    we    = 1'b1;
    waddr = k[IW-1:0];
    wdata = rdata;
    case (ctl.wr)
      ffba_pkg::WR_SHIFT:  begin
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      ffba_pkg::WR_REST:   begin
        waddr = k[IW-1:0];
        wdata = {1'b1, SW'(fsize_x - need_x)};
      end
      ffba_pkg::WR_SHRINK: begin
        waddr = fidx;
        wdata = {1'b0, SW'(req)};
      end
      ffba_pkg::WR_APPEND: begin
        waddr = count[IW-1:0];
        wdata = {1'b0, SW'(req)};
      end
      ffba_pkg::WR_FREE:   begin
        waddr = fidx;
        wdata = {1'b1, fsize};
      end
      default: we = 1'b0;
    endcase
  end

  // Block table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctl.rd_en) rdata <= mem[raddr];
  end

  // Table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      top   <= '0;
    end else begin
      if (ctl.wr == ffba_pkg::WR_APPEND) begin
        count <= count + CW'(1);
        top   <= top + need_x;
      end else if (ctl.cnt_inc) begin
        count <= count + CW'(1);
      end
    end
  end

  // Item, scan, found-entry, shift index and result registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act   <= item.action;
      req   <= item.request_bytes;
      daddr <= item.data_address;
    end
    if (ctl.scan_clr) begin
      idx <= '0;
      pos <= '0;
    end else if (ctl.adv) begin
      idx <= idx + CW'(1);
      pos <= pos + HDR_X + size_x;
    end
    if (ctl.found_latch) begin
      fidx   <= idx[IW-1:0];
      fstart <= pos;
      fsize  <= rdata[SW-1:0];
    end
    if (ctl.k_init) k <= count;
    else if (ctl.k_dec) k <= km1;
    if (ctl.res_set) begin
      res_st <= ctl.res_st;
      case (ctl.res_sel)
        ffba_pkg::ASEL_START: res_addr <= start_addr[15:0];
        ffba_pkg::ASEL_TOP:   res_addr <= top_addr[15:0];
        default:              res_addr <= '0;
      endcase
    end
  end

  assign result.result_address = res_addr;
  assign result.status         = res_st;

endmodule

/* rtl/ffba_ctrl.sv */
// Controller of the first-fit block allocator: sequences decode, table
// scan, free, entry shift, split and append. Uses ffba_pkg.
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_EV, S_ACT, S_APPEND, S_FREE_OLD,
    S_SHIFT_RD, S_SHIFT_WR, S_SPLIT_A, S_SPLIT_B, S_FINISH
  } state_t;

  state_t state, state_next;
  logic   fit, fit_next;
  logic   found, found_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    fit_next        = fit;
    found_next      = found;
    ctl             = '0;
    ctl.wr          = ffba_pkg::WR_NONE;
    ctl.res_sel     = ffba_pkg::ASEL_NONE;
    ctl.res_st      = ffba_pkg::ST_OK;
    ctl.fit         = fit;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        found_next = 1'b0;
        if (sts.action == ffba_pkg::ACT_NOP ||
            (sts.action == ffba_pkg::ACT_FREE && sts.daddr_zero)) begin
          ctl.res_set = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.action == ffba_pkg::ACT_ALLOC || sts.daddr_zero) begin
          if (sts.full) begin
            ctl.res_set = 1'b1;
            ctl.res_st  = ffba_pkg::ST_TABLE;
            state_next  = S_FINISH;
          end else begin
            fit_next     = 1'b1;
            ctl.scan_clr = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end else begin
          fit_next     = 1'b0;
          ctl.scan_clr = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          if (fit) begin
            state_next = S_APPEND;
          end else begin
            ctl.res_set = 1'b1;
            ctl.res_st  = ffba_pkg::ST_ADDR;
            state_next  = S_FINISH;
          end
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.hit) begin
          ctl.found_latch = 1'b1;
          state_next      = S_ACT;
        end else begin
          ctl.adv    = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_ACT: begin
        found_next = 1'b1;
        if (fit) begin
          ctl.k_init = 1'b1;
          state_next = S_SHIFT_RD;
        end else if (sts.action == ffba_pkg::ACT_FREE) begin
          ctl.wr      = ffba_pkg::WR_FREE;
          ctl.res_set = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.full) begin
          ctl.res_set = 1'b1;
          ctl.res_st  = ffba_pkg::ST_TABLE;
          state_next  = S_FINISH;
        end else if (sts.splittable) begin
          ctl.k_init = 1'b1;
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ctl.res_set = 1'b1;
        if (!sts.heap_ok) begin
          ctl.res_st = ffba_pkg::ST_HEAP;
          state_next = S_FINISH;
        end else begin
          ctl.wr      = ffba_pkg::WR_APPEND;
          ctl.res_sel = ffba_pkg::ASEL_TOP;
          state_next  = found ? S_FREE_OLD : S_FINISH;
        end
      end
      S_FREE_OLD: begin
        ctl.wr     = ffba_pkg::WR_FREE;
        state_next = S_FINISH;
      end
      S_SHIFT_RD: begin
        if (sts.k_done) begin
          state_next = S_SPLIT_A;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_k   = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl.wr     = ffba_pkg::WR_SHIFT;
        ctl.k_dec  = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_SPLIT_A: begin
        ctl.wr     = ffba_pkg::WR_REST;
        state_next = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        ctl.wr      = ffba_pkg::WR_SHRINK;
        ctl.cnt_inc = 1'b1;
        ctl.res_set = 1'b1;
        ctl.res_sel = ffba_pkg::ASEL_START;
        state_next  = S_FINISH;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit   <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      fit   <= fit_next;
      found <= found_next;
    end
  end

endmodule

/* tb/tb_first_fit_block_allocator_core.sv */
// Testbench for first_fit_block_allocator_core: directed and random allocate,
// free and reallocate beats checked against an in-bench allocator predictor.
// Depends on ffba_pkg and the core RTL.
module tb_first_fit_block_allocator_core;

  localparam int HEAP_BYTES   = 65536;
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int CYCLE_LIMIT  = 1500000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  ffba_pkg::item_t   item;
  logic              done;
  ffba_pkg::result_t result;

  first_fit_block_allocator_core #(
    .HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  // Predictor state: block table in address order plus heap top
  int unsigned       heap_sizes [MAX_BLOCKS];
  bit                heap_free  [MAX_BLOCKS];
  int unsigned       heap_blocks;
  int unsigned       heap_top;
  ffba_pkg::result_t pending_results[$];
  int unsigned       live_addrs[$];
  int                errors;
  int unsigned       cycles;
  bit                gaps_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit splittable(int unsigned have, int unsigned req);
    return have > req && (have - req) > HEADER_BYTES;
  endfunction

  function automatic int find_data(int unsigned addr);
    int unsigned pos;
    pos = 0;
    for (int i = 0; i < heap_blocks; i++) begin
      if (pos + HEADER_BYTES == addr) return i;
      pos += HEADER_BYTES + heap_sizes[i];
    end
    return -1;
  endfunction

  function automatic void split_at(int i, int unsigned req);
    int unsigned rest;
    rest = heap_sizes[i] - req - HEADER_BYTES;
    for (int k = heap_blocks; k > i + 1; k--) begin
      heap_sizes[k] = heap_sizes[k-1];
      heap_free[k]  = heap_free[k-1];
    end
    heap_sizes[i+1] = rest;
    heap_free[i+1]  = 1'b1;
    heap_sizes[i]   = req;
    heap_free[i]    = 1'b0;
    heap_blocks++;
  endfunction

  function automatic logic [1:0] append_at_top(int unsigned req, ref int unsigned addr);
    if (heap_blocks >= MAX_BLOCKS) return ffba_pkg::ST_TABLE;
    if (heap_top + HEADER_BYTES + req > HEAP_BYTES) return ffba_pkg::ST_HEAP;
    heap_sizes[heap_blocks] = req;
    heap_free[heap_blocks]  = 1'b0;
    heap_blocks++;
    addr = heap_top + HEADER_BYTES;
    heap_top += HEADER_BYTES + req;
    return ffba_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] first_fit(int unsigned req, ref int unsigned addr);
    int unsigned pos;
    if (heap_blocks >= MAX_BLOCKS) return ffba_pkg::ST_TABLE;
    pos = 0;
    for (int i = 0; i < heap_blocks; i++) begin
      if (heap_free[i] && splittable(heap_sizes[i], req)) begin
        split_at(i, req);
        addr = pos + HEADER_BYTES;
        return ffba_pkg::ST_OK;
      end
      pos += HEADER_BYTES + heap_sizes[i];
    end
    return append_at_top(req, addr);
  endfunction

  // Work out the result of one accepted beat and update the table
  function automatic ffba_pkg::result_t predict_heap(ffba_pkg::item_t it);
    int unsigned       addr;
    logic [1:0]        st;
    int                i;
    ffba_pkg::result_t r;
    addr = 0;
    st   = ffba_pkg::ST_OK;
    case (it.action)
      ffba_pkg::ACT_ALLOC: st = first_fit(it.request_bytes, addr);
      ffba_pkg::ACT_FREE: begin
        if (it.data_address != 0) begin
          i = find_data(it.data_address);
          if (i < 0) st = ffba_pkg::ST_ADDR;
          else heap_free[i] = 1'b1;
        end
      end
      ffba_pkg::ACT_REALLOC: begin
        if (it.data_address == 0) st = first_fit(it.request_bytes, addr);
        else begin
          i = find_data(it.data_address);
          if (i < 0) st = ffba_pkg::ST_ADDR;
          else if (heap_blocks >= MAX_BLOCKS) st = ffba_pkg::ST_TABLE;
          else if (splittable(heap_sizes[i], it.request_bytes)) begin
            split_at(i, it.request_bytes);
            addr = it.data_address;
          end else begin
            st = append_at_top(it.request_bytes, addr);
            if (st == ffba_pkg::ST_OK) heap_free[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (st != ffba_pkg::ST_OK) addr = 0;
    r.result_address = addr[15:0];
    r.status = st;
    if (addr != 0) live_addrs.push_back(addr);
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    ffba_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.result_address !== want.result_address)
          $display("%0t: result_address expected %h actual %h", $time,
                   want.result_address, result.result_address);
        if (result.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, result.status);
        if (result !== want) errors++;
      end
    end
  end

  // Drive one beat; prediction happens at the accepting edge
  task automatic send_beat(logic [1:0] act, logic [16:0] req, logic [15:0] daddr);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item  <= '{act, req, daddr};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_heap(item));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_addr();
    if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0)
      return 16'($urandom_range(0, 65535));
    return 16'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
  endfunction

  // Directed: extremes, every action and the special cases
  task automatic test_directed();
    send_beat(ffba_pkg::ACT_FREE, 0, 0);             // free of none
    send_beat(ffba_pkg::ACT_FREE, 0, 16'd24);        // unknown address on empty table
    send_beat(ffba_pkg::ACT_ALLOC, 0, 0);            // zero request
    send_beat(ffba_pkg::ACT_ALLOC, 17'd100, 0);
    send_beat(ffba_pkg::ACT_ALLOC, 17'd65536, 0);    // heap exhausted
    send_beat(ffba_pkg::ACT_FREE, 0, 16'd48);        // free block of 100
    send_beat(ffba_pkg::ACT_FREE, 0, 16'd48);        // already free
    send_beat(ffba_pkg::ACT_ALLOC, 17'd76, 0);       // no room for a header: append
    send_beat(ffba_pkg::ACT_ALLOC, 17'd75, 0);       // exact split boundary
    send_beat(ffba_pkg::ACT_REALLOC, 17'd10, 16'd48);
    send_beat(ffba_pkg::ACT_REALLOC, 17'd500, 16'd48);
    send_beat(ffba_pkg::ACT_REALLOC, 17'd5, 0);      // realloc of none
    send_beat(ffba_pkg::ACT_REALLOC, 17'd5, 16'd7);  // unknown address
    send_beat(ffba_pkg::ACT_REALLOC, 17'h1FFFF, 16'd24);
    send_beat(ffba_pkg::ACT_NOP, 17'h1FFFF, 16'hFFFF);
    send_beat(ffba_pkg::ACT_FREE, 17'h1FFFF, 16'hFFFF);
    send_beat(ffba_pkg::ACT_ALLOC, 17'd65000, 0);    // near heap exhaustion
    wait_drained();
  endtask

  // Fill the table with small blocks to reach table full
  task automatic test_table_full();
    for (int n = 0; n < 60; n++)
      send_beat(ffba_pkg::ACT_ALLOC, 17'($urandom_range(0, 40)), 0);
    send_beat(ffba_pkg::ACT_REALLOC, 0, live_addrs[0][15:0]);
    send_beat(ffba_pkg::ACT_FREE, 0, live_addrs[1][15:0]);
    send_beat(ffba_pkg::ACT_ALLOC, 0, 0);
    wait_drained();
  endtask

  // Random mix; mostly valid addresses and modest sizes
  task automatic test_random(int count);
    logic [1:0]  act;
    logic [16:0] req;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: act = ffba_pkg::ACT_ALLOC;
        3, 4, 5: act = ffba_pkg::ACT_FREE;
        6, 7, 8: act = ffba_pkg::ACT_REALLOC;
        default: act = ffba_pkg::ACT_NOP;
      endcase
      case ($urandom_range(0, 7))
        0:       req = 17'($urandom_range(0, 17'h1FFFF));
        1:       req = 17'($urandom_range(0, 4096));
        default: req = 17'($urandom_range(0, 300));
      endcase
      send_beat(act, req, $urandom_range(0, 4) == 0 ? 16'd0 : pick_addr());
      if (n % 400 == 399) wait_drained();
    end
  endtask

  initial begin
    cycles  = 0;
    errors  = 0;
    gaps_on = 1'b1;
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(1200);
    gaps_on = 1'b0;
    test_random(300);
    wait_drained();
    repeat (4 * MAX_BLOCKS + 20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
